/* sv/hcas_pkg.sv */
package hcas_pkg;

	localparam int MAX_SIDE_DEF    = 64;
	localparam int HEIGHT_BITS_DEF = 16;

	localparam int POS_W      = 24;
	localparam int DIM_W      = 7;
	localparam int SIZE_Z_W   = 16;
	localparam int IDX_W      = 12;
	localparam int HIN_W      = 16;
	localparam int RES_W      = 25;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// The average over five cells in Q8.8 is folded into one divide by 5 << FRAC_BITS.
	localparam int NUM_CELLS = 5;
	localparam int FRAC_BITS = 8;

	localparam longint RES_MAX = 64'sd16777215;
	localparam longint RES_MIN = -64'sd16777216;

	localparam logic [DIM_W-1:0]    GRID_WIDTH_RST  = 7'd64;
	localparam logic [DIM_W-1:0]    GRID_HEIGHT_RST = 7'd64;
	localparam logic [POS_W-1:0]    SIZE_X_RST      = 24'd16384;
	localparam logic [POS_W-1:0]    SIZE_Y_RST      = 24'd16384;
	localparam logic [SIZE_Z_W-1:0] SIZE_Z_RST      = 16'd256;

	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GRID_WIDTH,
		REG_GRID_HEIGHT,
		REG_SIZE_X,
		REG_SIZE_Y,
		REG_SIZE_Z
	} cfg_reg_t;

	typedef enum logic [2:0] {
		CELL_CENTER,
		CELL_DOWN,
		CELL_UP,
		CELL_RIGHT,
		CELL_LEFT
	} cell_sel_t;

	typedef struct packed {
		logic      load;
		logic      mem_we;
		logic      div_start;
		logic      rd_en;
		cell_sel_t nbr;
		logic      acc_clr;
		logic      acc_en;
		logic      mul_en;
		logic      d5_load;
		logic      out_load;
		logic      out_zero;
	} hcas_cmd_t;

	typedef struct packed {
		logic is_query;
		logic query_ok;
		logic div_done;
		logic d5_done;
	} hcas_sts_t;

endpackage

/* sv/hcas_if.sv */
interface hcas_req_if import hcas_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic                    req_type;
	logic [IDX_W-1:0]        cell_index;
	logic signed [HIN_W-1:0] cell_height;
	logic [POS_W-1:0]        query_x;
	logic [POS_W-1:0]        query_y;

	modport source (output valid, req_type, cell_index, cell_height, query_x, query_y,
		input ready);
	modport sink (input valid, req_type, cell_index, cell_height, query_x, query_y,
		output ready);
endinterface

interface hcas_rsp_if import hcas_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [RES_W-1:0] height_result;
	logic                    in_range;

	modport source (output valid, height_result, in_range, input ready);
	modport sink (input valid, height_result, in_range, output ready);
endinterface

interface hcas_cfg_if import hcas_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* sv/hcas_div.sv */
// Restoring divider for a quotient known to stay below 2**QB; one quotient bit a cycle.
module hcas_div import hcas_pkg::*; #(
	parameter int QB = 7
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [POS_W+QB-1:0]   num,
	input  logic [POS_W-1:0]      den,
	output logic                  busy,
	output logic [QB-1:0]         quo
);

	localparam int NW   = POS_W + QB;
	localparam int CNTW = (QB > 1) ? $clog2(QB) : 1;

	logic            busy_q;
	logic [CNTW-1:0] cnt_q;
	logic [NW-1:0]   rem_q;
	logic [NW-1:0]   dsr_q;
	logic [QB-1:0]   quo_q;
	logic            zero_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNTW'(QB - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - CNTW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= num;
			dsr_q  <= NW'(den) << (QB - 1);
			quo_q  <= '0;
			zero_q <= (den == '0);
		end else if (busy_q) begin
			if (rem_q >= dsr_q) begin
				rem_q <= rem_q - dsr_q;
				quo_q <= {quo_q[QB-2:0], 1'b1};
			end else begin
				quo_q <= {quo_q[QB-2:0], 1'b0};
			end
			dsr_q <= dsr_q >> 1;
		end
	end

	// A zero world size only admits position zero, which maps to index zero.
	assign quo  = zero_q ? '0 : quo_q;
	assign busy = busy_q;

endmodule

/* sv/hcas_datapath.sv */
module hcas_datapath import hcas_pkg::*; #(
	parameter int MAX_SIDE    = MAX_SIDE_DEF,
	parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  hcas_cmd_t               cmd,
	output hcas_sts_t               sts,
	input  logic                    req_type,
	input  logic [IDX_W-1:0]        cell_index,
	input  logic signed [HIN_W-1:0] cell_height,
	input  logic [POS_W-1:0]        query_x,
	input  logic [POS_W-1:0]        query_y,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	output logic signed [RES_W-1:0] height_result,
	output logic                    in_range
);

	localparam int DW    = $clog2(MAX_SIDE + 1);
	localparam int AW    = $clog2(MAX_SIDE * MAX_SIDE);
	localparam int DEPTH = MAX_SIDE * MAX_SIDE;
	localparam int HB    = HEIGHT_BITS;
	localparam int SW    = HB + 3;
	localparam int PW    = SW + SIZE_Z_W + 1;
	localparam int VW    = PW - FRAC_BITS;
	localparam int CW    = (VW + 1 > RES_W) ? VW + 1 : RES_W;
	localparam int NW    = POS_W + DW;

	// ceil(2**30 / 5); the product shifted right by 30 is exact for every value below 2**30.
	localparam int                  D5_SHIFT = 30;
	localparam logic [D5_SHIFT-1:0] D5_MAGIC = 30'd214748365;

	function automatic logic [DW-1:0] eff_dim(input logic [DIM_W-1:0] d);
		if (d == '0) begin
			return DW'(1);
		end else if (32'(d) > 32'(MAX_SIDE)) begin
			return DW'(MAX_SIDE);
		end
		return DW'(d);
	endfunction

	function automatic logic [DW-1:0] clip(input logic [DW:0] v, input logic [DW-1:0] lim);
		return (v > {1'b0, lim}) ? lim : v[DW-1:0];
	endfunction

	// Configuration registers.
	logic [DIM_W-1:0]    grid_width_q;
	logic [DIM_W-1:0]    grid_height_q;
	logic [POS_W-1:0]    size_x_q;
	logic [POS_W-1:0]    size_y_q;
	logic [SIZE_Z_W-1:0] size_z_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= GRID_WIDTH_RST;
			grid_height_q <= GRID_HEIGHT_RST;
			size_x_q      <= SIZE_X_RST;
			size_y_q      <= SIZE_Y_RST;
			size_z_q      <= SIZE_Z_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_GRID_WIDTH:  grid_width_q  <= cfg_data[DIM_W-1:0];
				REG_GRID_HEIGHT: grid_height_q <= cfg_data[DIM_W-1:0];
				REG_SIZE_X:      size_x_q      <= cfg_data[POS_W-1:0];
				REG_SIZE_Y:      size_y_q      <= cfg_data[POS_W-1:0];
				REG_SIZE_Z:      size_z_q      <= cfg_data[SIZE_Z_W-1:0];
				default: ;
			endcase
		end
	end

	// Captured request.
	logic                    req_type_q;
	logic [IDX_W-1:0]        cell_index_q;
	logic signed [HIN_W-1:0] cell_height_q;
	logic [POS_W-1:0]        query_x_q;
	logic [POS_W-1:0]        query_y_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q    <= req_type;
			cell_index_q  <= cell_index;
			cell_height_q <= cell_height;
			query_x_q     <= query_x;
			query_y_q     <= query_y;
		end
	end

	logic [DW-1:0]   w;
	logic [DW-1:0]   h;
	logic [2*DW-1:0] wh;
	logic            write_ok;
	logic            query_ok;

	assign w        = eff_dim(grid_width_q);
	assign h        = eff_dim(grid_height_q);
	assign wh       = (2*DW)'(w) * (2*DW)'(h);
	assign write_ok = 32'(cell_index_q) < 32'(wh);
	assign query_ok = (query_x_q <= size_x_q) && (query_y_q <= size_y_q);

	// Position to column and row.
	logic [DW-1:0] col_q;
	logic [DW-1:0] row_q;
	logic          busy_x;
	logic          busy_y;

	hcas_div #(.QB(DW)) u_div_x (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (NW'(query_x_q) * NW'(w)),
		.den   (size_x_q),
		.busy  (busy_x),
		.quo   (col_q)
	);

	hcas_div #(.QB(DW)) u_div_y (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.div_start),
		.num   (NW'(query_y_q) * NW'(h)),
		.den   (size_y_q),
		.busy  (busy_y),
		.quo   (row_q)
	);

	// Neighbor indices; a step to -1 reflects to 1 and every index clamps at the far edge.
	logic [DW-1:0] wm1, hm1;
	logic [DW-1:0] r0, rp, rm, c0, cp, cm;
	logic [DW-1:0] row, col;
	logic [2*DW-1:0] lin;
	logic [AW-1:0] raddr;

	assign wm1 = w - DW'(1);
	assign hm1 = h - DW'(1);
	assign r0  = clip({1'b0, row_q}, hm1);
	assign rp  = clip({1'b0, row_q} + (DW+1)'(1), hm1);
	assign rm  = clip((row_q == '0) ? (DW+1)'(1) : {1'b0, row_q} - (DW+1)'(1), hm1);
	assign c0  = clip({1'b0, col_q}, wm1);
	assign cp  = clip({1'b0, col_q} + (DW+1)'(1), wm1);
	assign cm  = clip((col_q == '0) ? (DW+1)'(1) : {1'b0, col_q} - (DW+1)'(1), wm1);

	always_comb begin
		row = r0;
		col = c0;
		case (cmd.nbr)
			CELL_DOWN:  row = rp;
			CELL_UP:    row = rm;
			CELL_RIGHT: col = cp;
			CELL_LEFT:  col = cm;
			default: ;
		endcase
	end

	assign lin   = (2*DW)'(row) * (2*DW)'(w) + (2*DW)'(col);
	assign raddr = AW'(lin);

	// Height store, one write or one read a cycle.
	logic [HB-1:0]        store_q [DEPTH];
	logic signed [HB-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (cmd.mem_we && write_ok) begin
			store_q[AW'(cell_index_q)] <= HB'(cell_height_q);
		end
		if (cmd.rd_en) begin
			rdata_q <= store_q[raddr];
		end
	end

	// Sum of five cells, then the size_z product.
	logic signed [SW-1:0] acc_q;
	logic signed [PW-1:0] prod_q;

	always_ff @(posedge clk) begin
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_en) begin
			acc_q <= acc_q + SW'(rdata_q);
		end
		if (cmd.mul_en) begin
			prod_q <= acc_q * $signed({1'b0, size_z_q});
		end
	end

	// Floor divide by five on the magnitude by a reciprocal multiply. A negative value v
	// becomes -v + 4 so the truncated quotient gives the floor after negation. With
	// 16-bit heights the magnitude stays far below 2**30.
	logic [VW-1:0]         vu;
	logic [VW-1:0]         m_init;
	logic [VW-1:0]         m_q;
	logic                  neg_q;
	logic                  d5_busy_q;
	logic [2*D5_SHIFT-1:0] p5;
	logic [VW-1:0]         quo5_q;

	assign vu     = prod_q[PW-1:FRAC_BITS];
	assign m_init = prod_q[PW-1] ? (~vu + VW'(NUM_CELLS)) : vu;
	assign p5     = (2*D5_SHIFT)'(D5_SHIFT'(m_q)) * (2*D5_SHIFT)'(D5_MAGIC);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d5_busy_q <= 1'b0;
		end else if (cmd.d5_load) begin
			d5_busy_q <= 1'b1;
		end else if (d5_busy_q) begin
			d5_busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.d5_load) begin
			m_q   <= m_init;
			neg_q <= prod_q[PW-1];
		end
		if (d5_busy_q) begin
			quo5_q <= VW'(p5[2*D5_SHIFT-1:D5_SHIFT]);
		end
	end

	logic signed [CW-1:0]    res_ext;
	logic signed [RES_W-1:0] res_sat;

	always_comb begin
		res_ext = neg_q ? -$signed(CW'(quo5_q)) : $signed(CW'(quo5_q));
		if (res_ext > CW'(RES_MAX)) begin
			res_sat = RES_W'(RES_MAX);
		end else if (res_ext < CW'(RES_MIN)) begin
			res_sat = RES_W'(RES_MIN);
		end else begin
			res_sat = RES_W'(res_ext);
		end
	end

	// Output register.
	logic signed [RES_W-1:0] res_q;
	logic                    ok_q;

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			if (cmd.out_zero) begin
				res_q <= '0;
				ok_q  <= (req_type_q == REQ_WRITE) && write_ok;
			end else begin
				res_q <= res_sat;
				ok_q  <= 1'b1;
			end
		end
	end

	assign height_result = res_q;
	assign in_range      = ok_q;

	assign sts.is_query = (req_type_q == REQ_QUERY);
	assign sts.query_ok = query_ok;
	assign sts.div_done = !busy_x && !busy_y;
	assign sts.d5_done  = !d5_busy_q;

endmodule

/* sv/hcas_ctrl.sv */
module hcas_ctrl import hcas_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output hcas_cmd_t cmd,
	input  hcas_sts_t sts
);

	localparam int RCW = $clog2(NUM_CELLS + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_DIV,
		S_READ,
		S_MUL,
		S_D5LOAD,
		S_D5,
		S_FINISH
	} state_t;

	state_t         state_q;
	logic           in_ready_q;
	logic           out_valid_q;
	logic           zero_q;
	logic [RCW-1:0] rd_cnt_q;

	always_comb begin
		cmd          = '0;
		cmd.load     = in_valid && in_ready_q;
		cmd.out_zero = zero_q;
		case (state_q)
			S_DECODE: begin
				cmd.acc_clr   = 1'b1;
				cmd.mem_we    = !sts.is_query;
				cmd.div_start = sts.is_query && sts.query_ok;
			end
			S_READ: begin
				// Reads are issued at counts zero to four; data lands one count later.
				cmd.rd_en  = 32'(rd_cnt_q) < NUM_CELLS;
				cmd.acc_en = rd_cnt_q != '0;
				if (32'(rd_cnt_q) < NUM_CELLS) begin
					cmd.nbr = cell_sel_t'(rd_cnt_q);
				end
			end
			S_MUL:    cmd.mul_en = 1'b1;
			S_D5LOAD: cmd.d5_load = 1'b1;
			S_FINISH: cmd.out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_ready_q  <= 1'b0;
			out_valid_q <= 1'b0;
			zero_q      <= 1'b0;
			rd_cnt_q    <= '0;
		end else begin
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					in_ready_q <= 1'b1;
					if (cmd.load) begin
						in_ready_q <= 1'b0;
						state_q    <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (sts.is_query && sts.query_ok) begin
						zero_q  <= 1'b0;
						state_q <= S_DIV;
					end else begin
						zero_q  <= 1'b1;
						state_q <= S_FINISH;
					end
				end
				S_DIV: begin
					if (sts.div_done) begin
						rd_cnt_q <= '0;
						state_q  <= S_READ;
					end
				end
				S_READ: begin
					if (32'(rd_cnt_q) == NUM_CELLS) begin
						state_q <= S_MUL;
					end else begin
						rd_cnt_q <= rd_cnt_q + RCW'(1);
					end
				end
				S_MUL:    state_q <= S_D5LOAD;
				S_D5LOAD: state_q <= S_D5;
				S_D5: begin
					if (sts.d5_done) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (cmd.out_load) begin
						in_ready_q <= 1'b1;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign in_ready  = in_ready_q;
	assign out_valid = out_valid_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result register loaded while a beat is still pending");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready_q |-> (state_q == S_IDLE))
		else $error("input ready outside the idle state");

	a_acc_follows_read: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc_en |-> $past(cmd.rd_en))
		else $error("accumulate without a store read in the cycle before");

endmodule

/* sv/heightmap_cross_average_sampler.sv */
// Channel  Dir  Payload                                                  Accepted when
// req      in   req_type, cell_index, cell_height, query_x, query_y      valid && ready
// rsp      out  height_result, in_range                                  valid && ready
// cfg      in   index (register), data                                   valid && ready
//
// A write or an out-of-range query goes from IDLE through DECODE to FINISH.
// A query also passes through the DIV, READ, MUL, D5LOAD and D5 states: the row
// and column dividers give one bit a cycle, the store port gives one of the five reads
// a cycle, and the divide by five is a single reciprocal multiply.
// Reset clears the configuration to its defaults; the height store is not cleared.
// A result waiting on rsp holds the next item only once that item is finished.
module heightmap_cross_average_sampler import hcas_pkg::*; #(
	parameter int MAX_SIDE    = MAX_SIDE_DEF,
	parameter int HEIGHT_BITS = HEIGHT_BITS_DEF
) (
	input logic              clk,
	input logic              arst_n,
	hcas_req_if.sink         req,
	hcas_rsp_if.source       rsp,
	hcas_cfg_if.sink         cfg
);

	hcas_cmd_t cmd;
	hcas_sts_t sts;

	assign cfg.ready = 1'b1;

	hcas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (req.ready),
		.out_valid(rsp.valid),
		.out_ready(rsp.ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	hcas_datapath #(
		.MAX_SIDE   (MAX_SIDE),
		.HEIGHT_BITS(HEIGHT_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.req_type     (req.req_type),
		.cell_index   (req.cell_index),
		.cell_height  (req.cell_height),
		.query_x      (req.query_x),
		.query_y      (req.query_y),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.height_result(rsp.height_result),
		.in_range     (rsp.in_range)
	);

endmodule

/* dv/heightmap_cross_average_sampler_tb.sv */
module heightmap_cross_average_sampler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import hcas_pkg::*;

	localparam int     ITEMS_TOTAL   = 950;
	localparam int     NUM_PHASES    = 8;
	localparam int     SETTLE_CYCLES = 64;
	localparam int     CYCLE_LIMIT   = 1000000;
	localparam int     STORE_CELLS   = MAX_SIDE_DEF * MAX_SIDE_DEF;
	localparam longint AVG_DIV       = longint'(NUM_CELLS) << FRAC_BITS;

	localparam logic signed [HIN_W-1:0] HGT_MAX = 16'sh7FFF;
	localparam logic signed [HIN_W-1:0] HGT_MIN = 16'sh8000;

	typedef struct {
		logic                    kind;
		logic [IDX_W-1:0]        cell_index;
		logic signed [HIN_W-1:0] cell_height;
		logic [POS_W-1:0]        query_x;
		logic [POS_W-1:0]        query_y;
	} req_item_t;

	typedef struct {
		logic signed [RES_W-1:0] height;
		logic                    in_range;
	} sample_t;

	typedef logic [NUM_CELLS-1:0][IDX_W-1:0] cross_t;

	typedef enum logic [1:0] {
		RDY_ALWAYS,
		RDY_COIN,
		RDY_SPARSE,
		RDY_PERIODIC
	} rdy_mode_t;

	logic clk = 1'b0;
	logic arst_n = 1'b1;

	hcas_req_if req_bus ();
	hcas_rsp_if rsp_bus ();
	hcas_cfg_if cfg_bus ();

	heightmap_cross_average_sampler u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_bus),
		.rsp    (rsp_bus),
		.cfg    (cfg_bus)
	);

	req_item_t request_queue[$];
	sample_t   awaited_results[$];

	logic signed [HIN_W-1:0] height_mem [STORE_CELLS];
	bit                      cell_written [STORE_CELLS];

	logic [DIM_W-1:0]    grid_w_cfg;
	logic [DIM_W-1:0]    grid_h_cfg;
	logic [POS_W-1:0]    size_x_cfg;
	logic [POS_W-1:0]    size_y_cfg;
	logic [SIZE_Z_W-1:0] size_z_cfg;

	int items_made;
	int beats_sent;
	int queries_sent;
	int results_checked;
	int rejected_seen;
	int mismatch_count;
	int cycle_count;
	int settings_run;
	int gap_left;
	int burst_left;
	int mode_left;
	rdy_mode_t rdy_mode;
	sample_t   want;

	initial forever #6 clk = ~clk;

	function automatic int eff_dim(logic [DIM_W-1:0] d);
		if (d == 0) return 1;
		if (d > MAX_SIDE_DEF) return MAX_SIDE_DEF;
		return int'(d);
	endfunction

	// Negative neighbors reflect back into the grid, far ones clamp to the last row or column.
	function automatic int fold_index(longint v, int n);
		if (v < 0) v = -v;
		if (v > n - 1) v = n - 1;
		return int'(v);
	endfunction

	function automatic longint scale_pos(logic [POS_W-1:0] q, int n, logic [POS_W-1:0] sz);
		if (sz == 0) return 0;
		return (longint'(q) * n) / longint'(sz);
	endfunction

	function automatic cross_t cross_cells(logic [POS_W-1:0] qx, logic [POS_W-1:0] qy,
			int w, int h, logic [POS_W-1:0] sx, logic [POS_W-1:0] sy);
		longint r;
		longint c;
		int     r0;
		int     c0;
		cross_t cells;
		r  = scale_pos(qy, h, sy);
		c  = scale_pos(qx, w, sx);
		r0 = fold_index(r, h);
		c0 = fold_index(c, w);
		cells[CELL_CENTER] = IDX_W'(r0 * w + c0);
		cells[CELL_DOWN]   = IDX_W'(fold_index(r + 1, h) * w + c0);
		cells[CELL_UP]     = IDX_W'(fold_index(r - 1, h) * w + c0);
		cells[CELL_RIGHT]  = IDX_W'(r0 * w + fold_index(c + 1, w));
		cells[CELL_LEFT]   = IDX_W'(r0 * w + fold_index(c - 1, w));
		return cells;
	endfunction

	function automatic sample_t cross_average(logic kind, logic [IDX_W-1:0] idx,
			logic signed [HIN_W-1:0] hgt, logic [POS_W-1:0] qx, logic [POS_W-1:0] qy);
		int      w;
		int      h;
		cross_t  cells;
		longint  total;
		longint  prod;
		longint  quo;
		sample_t s;
		w = eff_dim(grid_w_cfg);
		h = eff_dim(grid_h_cfg);
		s.height   = '0;
		s.in_range = 1'b0;
		if (kind == REQ_WRITE) begin
			if (int'(idx) < w * h) begin
				height_mem[idx] = hgt;
				s.in_range = 1'b1;
			end
		end else if (qx <= size_x_cfg && qy <= size_y_cfg) begin
			cells = cross_cells(qx, qy, w, h, size_x_cfg, size_y_cfg);
			total = 0;
			for (int k = 0; k < NUM_CELLS; k++)
				total += longint'(height_mem[cells[k]]);
			prod = total * longint'(size_z_cfg);
			// Floor division, so negative averages round toward minus infinity.
			quo = (prod >= 0) ? prod / AVG_DIV : -((-prod + AVG_DIV - 1) / AVG_DIV);
			if (quo > RES_MAX) quo = RES_MAX;
			if (quo < RES_MIN) quo = RES_MIN;
			s.height   = quo[RES_W-1:0];
			s.in_range = 1'b1;
		end
		return s;
	endfunction

	function automatic logic signed [HIN_W-1:0] random_height();
		case ($urandom_range(0, 7))
			0: return HGT_MAX;
			1: return HGT_MIN;
			2: return '0;
			default: return HIN_W'($urandom);
		endcase
	endfunction

	function automatic logic [POS_W-1:0] rand_pos(logic [POS_W-1:0] sz);
		int unsigned lim;
		lim = sz;
		case ($urandom_range(0, 9))
			0: return '0;
			1: return sz;
			9: return (sz == '1) ? sz : POS_W'($urandom_range(32'hFF_FFFF, lim + 1));
			default: return POS_W'($urandom_range(lim, 0));
		endcase
	endfunction

	function automatic logic [DIM_W-1:0] rand_dim();
		if ($urandom_range(0, 4) == 0) return DIM_W'($urandom);
		return DIM_W'($urandom_range(12, 1));
	endfunction

	function automatic logic [POS_W-1:0] rand_size();
		if ($urandom_range(0, 2) == 0) return POS_W'($urandom);
		return POS_W'($urandom_range(8192, 1));
	endfunction

	task automatic push_write(logic [IDX_W-1:0] idx, logic signed [HIN_W-1:0] hgt);
		req_item_t it;
		it.kind        = REQ_WRITE;
		it.cell_index  = idx;
		it.cell_height = hgt;
		it.query_x     = POS_W'($urandom);
		it.query_y     = POS_W'($urandom);
		if (int'(idx) < eff_dim(grid_w_cfg) * eff_dim(grid_h_cfg))
			cell_written[idx] = 1'b1;
		request_queue.push_back(it);
		items_made++;
	endtask

	// Any cell the query will read gets a write ahead of it.
	task automatic push_query(logic [POS_W-1:0] qx, logic [POS_W-1:0] qy);
		cross_t    cells;
		req_item_t it;
		if (qx <= size_x_cfg && qy <= size_y_cfg) begin
			cells = cross_cells(qx, qy, eff_dim(grid_w_cfg), eff_dim(grid_h_cfg),
				size_x_cfg, size_y_cfg);
			for (int k = 0; k < NUM_CELLS; k++)
				if (!cell_written[cells[k]])
					push_write(cells[k], random_height());
		end
		it.kind        = REQ_QUERY;
		it.cell_index  = IDX_W'($urandom);
		it.cell_height = HIN_W'($urandom);
		it.query_x     = qx;
		it.query_y     = qy;
		request_queue.push_back(it);
		items_made++;
	endtask

	task automatic random_traffic(int target);
		int cells;
		cells = eff_dim(grid_w_cfg) * eff_dim(grid_h_cfg);
		while (items_made < target) begin
			if ($urandom_range(0, 9) >= 4)
				push_query(rand_pos(size_x_cfg), rand_pos(size_y_cfg));
			else if ($urandom_range(0, 9) == 0)
				push_write(IDX_W'($urandom), random_height());
			else
				push_write(IDX_W'($urandom_range(cells - 1, 0)), random_height());
		end
	endtask

	task automatic wait_drained();
		while (request_queue.size() != 0 || awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves valid high so that back-to-back writes need no second assignment in a step.
	task automatic write_reg(cfg_reg_t r, logic [CFG_DATA_W-1:0] d);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= r;
		cfg_bus.data  <= d;
		do @(posedge clk); while (!cfg_bus.ready);
		case (r)
			REG_GRID_WIDTH:  grid_w_cfg = d[DIM_W-1:0];
			REG_GRID_HEIGHT: grid_h_cfg = d[DIM_W-1:0];
			REG_SIZE_X:      size_x_cfg = d[POS_W-1:0];
			REG_SIZE_Y:      size_y_cfg = d[POS_W-1:0];
			REG_SIZE_Z:      size_z_cfg = d[SIZE_Z_W-1:0];
			default: ;
		endcase
	endtask

	task automatic configure(logic [DIM_W-1:0] gw, logic [DIM_W-1:0] gh,
			logic [POS_W-1:0] sx, logic [POS_W-1:0] sy, logic [SIZE_Z_W-1:0] sz);
		logic [CFG_DATA_W-1:0] junk;
		junk = ($urandom_range(0, 1) != 0) ? CFG_DATA_W'($urandom) : '0;
		write_reg(REG_GRID_WIDTH, {junk[CFG_DATA_W-1:DIM_W], gw});
		write_reg(REG_GRID_HEIGHT, {junk[CFG_DATA_W-1:DIM_W], gh});
		write_reg(REG_SIZE_X, sx);
		write_reg(REG_SIZE_Y, sy);
		write_reg(REG_SIZE_Z, {junk[CFG_DATA_W-1:SIZE_Z_W], sz});
		cfg_bus.valid <= 1'b0;
		settings_run++;
	endtask

	// Request driver: bursts of beats separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_bus.valid       <= 1'b0;
			req_bus.req_type    <= REQ_WRITE;
			req_bus.cell_index  <= '0;
			req_bus.cell_height <= '0;
			req_bus.query_x     <= '0;
			req_bus.query_y     <= '0;
			gap_left   = 0;
			burst_left = 0;
		end else begin
			if (req_bus.valid && req_bus.ready) begin
				awaited_results.push_back(cross_average(req_bus.req_type, req_bus.cell_index,
					req_bus.cell_height, req_bus.query_x, req_bus.query_y));
				if (req_bus.req_type == REQ_QUERY) queries_sent++;
				beats_sent++;
				void'(request_queue.pop_front());
			end
			if (!req_bus.valid || req_bus.ready) begin
				if (gap_left > 0) begin
					gap_left--;
					req_bus.valid <= 1'b0;
				end else if (request_queue.size() != 0) begin
					req_bus.valid       <= 1'b1;
					req_bus.req_type    <= request_queue[0].kind;
					req_bus.cell_index  <= request_queue[0].cell_index;
					req_bus.cell_height <= request_queue[0].cell_height;
					req_bus.query_x     <= request_queue[0].query_x;
					req_bus.query_y     <= request_queue[0].query_y;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 31);
						case ($urandom_range(0, 3))
							0: gap_left = 0;
							1, 2: gap_left = $urandom_range(1, 4);
							default: gap_left = $urandom_range(5, 25);
						endcase
					end
				end else begin
					req_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Result receiver: the stall pattern switches between a few modes.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_bus.ready <= 1'b0;
			rdy_mode  = RDY_ALWAYS;
			mode_left = 0;
		end else begin
			if (mode_left == 0) begin
				rdy_mode  = rdy_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(20, 300);
			end else begin
				mode_left--;
			end
			case (rdy_mode)
				RDY_ALWAYS: rsp_bus.ready <= 1'b1;
				RDY_COIN:   rsp_bus.ready <= ($urandom_range(0, 1) == 1);
				RDY_SPARSE: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
				default:    rsp_bus.ready <= ((cycle_count % 5) < 2);
			endcase
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			if (awaited_results.size() == 0) begin
				$error("unexpected result beat: height_result %0d, in_range %0b",
					rsp_bus.height_result, rsp_bus.in_range);
				mismatch_count++;
			end else begin
				want = awaited_results.pop_front();
				if (rsp_bus.height_result !== want.height) begin
					$error("height_result mismatch: expected %0d, actual %0d",
						want.height, rsp_bus.height_result);
					mismatch_count++;
				end
				if (rsp_bus.in_range !== want.in_range) begin
					$error("in_range mismatch: expected %0b, actual %0b",
						want.in_range, rsp_bus.in_range);
					mismatch_count++;
				end
				if (!want.in_range) rejected_seen++;
				results_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles with %0d results outstanding",
				cycle_count, awaited_results.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		arst_n        <= 1'b0;
		cfg_bus.valid <= 1'b0;
		cfg_bus.index <= REG_GRID_WIDTH;
		cfg_bus.data  <= '0;
		grid_w_cfg = GRID_WIDTH_RST;
		grid_h_cfg = GRID_HEIGHT_RST;
		size_x_cfg = SIZE_X_RST;
		size_y_cfg = SIZE_Y_RST;
		size_z_cfg = SIZE_Z_RST;
		settings_run = 1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < NUM_PHASES; p++) begin
			case (p)
				0: begin
					// Reset settings: full-scale cross at the origin, the far corners, points past the edge and one inside.
					push_write(0, HGT_MAX);
					push_write(1, HGT_MAX);
					push_write(MAX_SIDE_DEF, HGT_MAX);
					push_query(0, 0);
					push_write(0, HGT_MIN);
					push_write(1, HGT_MIN + 1);
					push_write(MAX_SIDE_DEF, HGT_MIN);
					push_query(0, 0);
					push_query(SIZE_X_RST, SIZE_Y_RST);
					push_query(SIZE_X_RST, 0);
					push_query(0, SIZE_Y_RST);
					push_query(SIZE_X_RST + 1, 0);
					push_query(0, SIZE_Y_RST + 1);
					push_query('1, '1);
					push_query(8000, 12345);
					push_write(STORE_CELLS - 1, -1);
				end
				1: configure(1, 1, 1, 1, 0);
				2: configure(64, 64, '1, '1, '1);
				3: configure(0, 127, 0, 0, SIZE_Z_W'($urandom));
				default: configure(rand_dim(), rand_dim(), rand_size(), rand_size(),
					SIZE_Z_W'($urandom));
			endcase
			// Once, the sender stops mid-setting until every result is back.
			if (p == 4) begin
				random_traffic(items_made + 40);
				wait_drained();
			end
			random_traffic((p + 1) * ITEMS_TOTAL / NUM_PHASES);
			wait_drained();
		end

		$display("Sent %0d request beats (%0d height queries) over %0d register settings.",
			beats_sent, queries_sent, settings_run);
		$display("Checked %0d results, %0d of them out of range or rejected writes.",
			results_checked, rejected_seen);
		if (mismatch_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

/* files.f */
sv/hcas_pkg.sv
sv/hcas_if.sv
sv/hcas_div.sv
sv/hcas_datapath.sv
sv/hcas_ctrl.sv
sv/heightmap_cross_average_sampler.sv
dv/heightmap_cross_average_sampler_tb.sv
